// ===== design/brl_pkg.sv =====
// brl_pkg: shared types and constants for the binary record loader.
// Used by brl_parser, brl_outbuf and binary_record_loader.
package brl_pkg;

  typedef enum logic [1:0] {
    EV_WRITE  = 2'd0,
    EV_DONE   = 2'd1,
    EV_CSUM   = 2'd2,
    EV_HEADER = 2'd3
  } event_kind_t;

  localparam logic [7:0]  HDR_DATA  = 8'h0d;
  localparam logic [7:0]  HDR_END   = 8'h0e;
  localparam logic [15:0] COUNT_MAX = 16'hffff;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [15:0] number;
    logic        jump;
  } brl_result_t;

endpackage

// ===== design/brl_parser.sv =====
// brl_parser: per-byte record parser state machine.
// Depends on brl_pkg; produces at most one result per accepted byte.
module brl_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                run_after_load,
  output logic                result_valid,
  output brl_pkg::brl_result_t result
);
  import brl_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ADDR,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_START,
    PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  field_byte_index, field_byte_index_next;
  logic [31:0] record_base, record_base_next;
  logic [15:0] record_length, record_length_next;
  logic [15:0] data_offset, data_offset_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sum_low_byte, sum_low_byte_next;
  logic [15:0] record_counter, record_counter_next;
  logic [15:0] offset_inc;
  logic [15:0] length_full;

  assign offset_inc  = data_offset + 16'd1;
  assign length_full = {rx_byte, record_length[7:0]};

  always_comb begin
    phase_next            = phase;
    field_byte_index_next = field_byte_index;
    record_base_next      = record_base;
    record_length_next    = record_length;
    data_offset_next      = data_offset;
    running_sum_next      = running_sum;
    sum_low_byte_next     = sum_low_byte;
    record_counter_next   = record_counter;
    result_valid          = 1'b0;
    result.kind           = EV_WRITE;
    result.address        = 32'd0;
    result.data           = 8'd0;
    result.number         = record_counter;
    result.jump           = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        field_byte_index_next = 2'd0;
        if (rx_byte == HDR_DATA) begin
          running_sum_next   = 16'd0;
          record_length_next = 16'd0;
          data_offset_next   = 16'd0;
          phase_next         = PH_ADDR;
        end else if (rx_byte == HDR_END) begin
          phase_next = PH_START;
        end else begin
          phase_next   = PH_HALT;
          result_valid = 1'b1;
          result.kind  = EV_HEADER;
        end
      end
      PH_ADDR, PH_START: begin
        record_base_next[8*field_byte_index +: 8] = rx_byte;
        if (field_byte_index == 2'd3) begin
          field_byte_index_next = 2'd0;
          if (phase == PH_START) begin
            phase_next     = PH_HALT;
            result_valid   = 1'b1;
            result.kind    = EV_DONE;
            result.address = record_base_next;
            result.jump    = run_after_load;
          end else begin
            phase_next = PH_LEN;
          end
        end else begin
          field_byte_index_next = field_byte_index + 2'd1;
        end
      end
      PH_LEN: begin
        if (field_byte_index == 2'd0) begin
          record_length_next    = {8'd0, rx_byte};
          field_byte_index_next = 2'd1;
        end else begin
          record_length_next    = length_full;
          field_byte_index_next = 2'd0;
          data_offset_next      = 16'd0;
          phase_next            = (length_full == 16'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_next = running_sum + {8'd0, rx_byte};
        data_offset_next = offset_inc;
        if (offset_inc == record_length) phase_next = PH_SUM;
        result_valid   = 1'b1;
        result.kind    = EV_WRITE;
        result.address = record_base + {16'd0, data_offset};
        result.data    = rx_byte;
      end
      PH_SUM: begin
        if (field_byte_index == 2'd0) begin
          sum_low_byte_next     = rx_byte;
          field_byte_index_next = 2'd1;
        end else begin
          field_byte_index_next = 2'd0;
          if ({rx_byte, sum_low_byte} != running_sum) begin
            phase_next   = PH_HALT;
            result_valid = 1'b1;
            result.kind  = EV_CSUM;
          end else begin
            if (record_counter != COUNT_MAX) record_counter_next = record_counter + 16'd1;
            phase_next = PH_HEADER;
          end
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
    if (!step) result_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      field_byte_index <= 2'd0;
      record_counter   <= 16'd1;
    end else if (step) begin
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      record_counter   <= record_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      record_base   <= record_base_next;
      record_length <= record_length_next;
      data_offset   <= data_offset_next;
      running_sum   <= running_sum_next;
      sum_low_byte  <= sum_low_byte_next;
    end
  end

endmodule

// ===== design/brl_outbuf.sv =====
// brl_outbuf: result register with one skid entry.
// Depends on brl_pkg for the result struct.
module brl_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  brl_pkg::brl_result_t push_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output brl_pkg::brl_result_t out_data,
  output logic                 full
);
  import brl_pkg::*;

  brl_result_t skid_data;
  logic        skid_valid;
  logic        take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) skid_data <= push_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== design/binary_record_loader.sv =====
// binary_record_loader: top level of the download record parser.
// Depends on brl_pkg, brl_parser and brl_outbuf.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) carries one stream byte per
//   request. Output channel (out_valid, out_stall, event_kind, ...) carries
//   memory writes, done, and the two error reports.
//   cfg_we/cfg_data write run_after_load; write only while the block is idle.
// Output: a result is registered in the output register, or in the skid
//   entry while a stalled result holds. Throughput: one byte per cycle
//   while in_stall is low; the parser updates its state per accepted byte
//   and the output register plus one skid entry decouple the sides.
// Stall: a stalled result holds; one more result is absorbed by the skid
//   entry, after which in_stall rises until the stalled result is taken.
// Reset: parser returns to awaiting a header, record count to 1,
//   run_after_load to 0, output channel empties. After done or an error
//   every byte is accepted and dropped until reset.
module binary_record_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [31:0] target_address,
  output logic [7:0]  write_data,
  output logic [15:0] record_number,
  output logic        jump_request
);
  import brl_pkg::*;

  logic        run_after_load;
  logic        accept;
  logic        result_valid;
  logic        full;
  brl_result_t result;
  brl_result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_after_load <= 1'b0;
    end else if (cfg_we) begin
      run_after_load <= cfg_data;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  brl_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .rx_byte        (rx_byte),
    .run_after_load (run_after_load),
    .result_valid   (result_valid),
    .result         (result)
  );

  brl_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

  assign event_kind     = out_data.kind;
  assign target_address = out_data.address;
  assign write_data     = out_data.data;
  assign record_number  = out_data.number;
  assign jump_request   = out_data.jump;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    full |-> out_valid)
    else $error("skid entry held while output register empty");

  a_jump_only_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && jump_request) |-> (event_kind == EV_DONE))
    else $error("jump request on a result other than done");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_CSUM || event_kind == EV_HEADER))
      |-> (target_address == 32'd0 && write_data == 8'd0))
    else $error("error result carries address or data");

endmodule
